// ----- src/iowkq_pkg.sv -----
// shared types, address map constants and reset table for the i/o window with key queue
package iowkq_pkg;

   localparam int unsigned COLOR_AW = 11;
   localparam int unsigned COLOR_DEPTH = 1 << COLOR_AW;

   // operation codes carried in req_tuser
   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_PUSH  = 2'd2;

   // address map
   localparam logic [15:0] FLOPPY_LO   = 16'hD080;
   localparam logic [15:0] FLOPPY_HI   = 16'hD09F;
   localparam logic [15:0] COLOR_LO    = 16'hD800;
   localparam logic [15:0] COLOR_1K_HI = 16'hDBFF;
   localparam logic [15:0] COLOR_HI    = 16'hDFFF;
   localparam logic [15:0] SYS_LO      = 16'hD600;
   localparam logic [15:0] SYS_HI      = 16'hD6FF;
   localparam logic [15:0] DECLINE_LO  = 16'hD640;
   localparam logic [15:0] DECLINE_HI  = 16'hD693;
   localparam logic [15:0] KEY_MODS    = 16'hD60A;
   localparam logic [15:0] KEY_ASCII   = 16'hD610;
   localparam logic [15:0] KEY_LIVE    = 16'hD611;
   localparam logic [15:0] KEY_PETSCII = 16'hD619;

   localparam logic [4:0] FLOPPY_STATUS_OFS = 5'h03;
   localparam logic [7:0] FLOPPY_STATUS     = 8'h08;

   // source of the read byte in the result stage
   localparam logic [2:0] SEL_NONE  = 3'd0;
   localparam logic [2:0] SEL_IMM   = 3'd1;
   localparam logic [2:0] SEL_COLOR = 3'd2;
   localparam logic [2:0] SEL_RF    = 3'd3;
   localparam logic [2:0] SEL_QMOD  = 3'd4;
   localparam logic [2:0] SEL_QASC  = 3'd5;
   localparam logic [2:0] SEL_QPET  = 3'd6;

   typedef struct packed {
      logic [2:0] sel;
      logic       handled;
      logic [7:0] imm;
      logic       has_key;
      logic       rf_valid;
      logic [7:0] rf_idx;
   } stage_type;

   typedef struct packed {
      logic [7:0] mods;
      logic [7:0] petscii;
      logic [7:0] ascii;
   } key_entry_type;

   // register file contents after reset
   function automatic logic [7:0] rf_reset_value(input logic [7:0] idx);
      logic [7:0] v;
      unique case (idx)
         8'h00:   v = 8'h80;
         8'h29:   v = 8'h03;
         8'h31:   v = 8'h08;
         8'h32:   v = 8'h4D;
         8'h33:   v = 8'h4D;
         8'h34:   v = 8'h53;
         8'h35:   v = 8'h4D;
         8'h7F:   v = 8'h55;
         8'hC5:   v = 8'h01;
         default: v = 8'h00;
      endcase
      return v;
   endfunction

endpackage

// ----- src/io_window_with_key_queue.sv -----
// i/o window: floppy stub, colour ram, system register file and keyboard queue
//
// Takes one bus read, bus write or key push per cycle unless the output stalls, and
// returns one result per item: the colour ram, register file and key queue memories are
// read at the transfer edge, and the result stage registers the selected byte into the
// output register. Writes, pops, flushes and pushes take effect at the transfer edge, so a
// following item always sees them. After reset the 2048-entry colour ram is cleared one
// entry per cycle; req_tready stays low until the clear is done, while csr writes are
// taken. Register file entries that were never written return their fixed reset values.
module io_window_with_key_queue #(
   parameter int unsigned KEY_QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [0:0]  csr_wdata,      // color_ram_2k
   input  logic        req_tvalid,
   output logic        req_tready,
   // address[15:0], write_data[23:16], key_ascii[31:24], key_petscii[39:32],
   // key_modifiers[47:40], live_modifiers[55:48]
   input  logic [55:0] req_tdata,
   input  logic [1:0]  req_tuser,      // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,      // read_data
   output logic [0:0]  rsp_tuser       // handled
);
   import iowkq_pkg::*;

   localparam int unsigned PTR_W = (KEY_QUEUE_DEPTH > 1) ? $clog2(KEY_QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(KEY_QUEUE_DEPTH + 1);

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(KEY_QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // memories
   logic [7:0]    color_mem [COLOR_DEPTH];
   logic [7:0]    rf_mem [256];
   key_entry_type key_mem [KEY_QUEUE_DEPTH];

   logic [7:0]    color_rd_ff;
   logic [7:0]    rf_rd_ff;
   key_entry_type key_rd_ff;

   logic [255:0]  rf_valid_ff, rf_valid_in;
   logic          cfg_2k_ff;
   logic          clr_busy_ff;
   logic [COLOR_AW-1:0] clr_idx_ff;

   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic          busy_ff, busy_in;
   stage_type     stage_ff, stage_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_data_ff, rsp_data_in;
   logic          rsp_handled_ff, rsp_handled_in;

   // request fields
   logic [1:0]  op;
   logic [15:0] addr;
   logic [7:0]  wdata;
   key_entry_type push_entry;
   logic [7:0]  live_mods;

   assign op               = req_tuser;
   assign addr             = req_tdata[15:0];
   assign wdata            = req_tdata[23:16];
   assign push_entry.ascii   = req_tdata[31:24];
   assign push_entry.petscii = req_tdata[39:32];
   assign push_entry.mods    = req_tdata[47:40];
   assign live_mods        = req_tdata[55:48];

   logic out_free, stage_move, accept;
   logic in_floppy, in_color_span, color_ok, in_sys;
   logic has_key, full;
   logic color_we, rf_we, do_pop, do_flush, do_push;
   logic [7:0] result_byte;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign stage_move = busy_ff && out_free;
   assign req_tready = !clr_busy_ff && (!busy_ff || out_free);
   assign accept     = req_tvalid && req_tready;

   assign in_floppy     = (addr >= FLOPPY_LO) && (addr <= FLOPPY_HI);
   assign in_color_span = (addr >= COLOR_LO) && (addr <= COLOR_HI);
   assign color_ok      = in_color_span && ((addr <= COLOR_1K_HI) || cfg_2k_ff);
   assign in_sys        = (addr >= SYS_LO) && (addr <= SYS_HI)
                          && !((addr >= DECLINE_LO) && (addr <= DECLINE_HI));

   assign has_key = (count_ff != '0);
   assign full    = (count_ff >= CNT_W'(KEY_QUEUE_DEPTH));

   // decode of the transfer into memory actions and the result stage
   always_comb begin
      stage_in          = '0;
      stage_in.sel      = SEL_NONE;
      stage_in.has_key  = has_key;
      stage_in.rf_idx   = addr[7:0];
      stage_in.rf_valid = rf_valid_ff[addr[7:0]];
      color_we = 1'b0;
      rf_we    = 1'b0;
      do_pop   = 1'b0;
      do_flush = 1'b0;
      do_push  = 1'b0;
      unique case (op)
         OP_READ: begin
            priority if (in_floppy) begin
               stage_in.handled = 1'b1;
               stage_in.sel     = SEL_IMM;
               stage_in.imm     = (addr[4:0] == FLOPPY_STATUS_OFS) ? FLOPPY_STATUS : 8'h00;
            end else if (in_color_span) begin
               stage_in.handled = color_ok;
               stage_in.sel     = color_ok ? SEL_COLOR : SEL_NONE;
            end else if (in_sys) begin
               stage_in.handled = 1'b1;
               priority if (addr == KEY_MODS) begin
                  stage_in.sel = SEL_QMOD;
               end else if (addr == KEY_ASCII) begin
                  stage_in.sel = SEL_QASC;
               end else if (addr == KEY_PETSCII) begin
                  stage_in.sel = SEL_QPET;
               end else if (addr == KEY_LIVE) begin
                  stage_in.sel = SEL_IMM;
                  stage_in.imm = live_mods;
               end else begin
                  stage_in.sel = SEL_RF;
               end
            end else begin
               stage_in.handled = 1'b0;
            end
         end
         OP_WRITE: begin
            priority if (in_color_span) begin
               stage_in.handled = color_ok;
               color_we         = color_ok;
            end else if (in_sys) begin
               stage_in.handled = 1'b1;
               priority if (addr == KEY_MODS) begin
                  do_flush = !wdata[7];
               end else if ((addr == KEY_ASCII) || (addr == KEY_PETSCII)) begin
                  do_pop = has_key;
               end else begin
                  rf_we = 1'b1;
               end
            end else begin
               stage_in.handled = 1'b0;
            end
         end
         OP_PUSH: begin
            stage_in.handled = !full;
            do_push          = !full;
         end
         default: begin
            stage_in.handled = 1'b0;
         end
      endcase
   end

   // queue pointers and register file valid bits
   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      rf_valid_in = rf_valid_ff;
      if (accept) begin
         if (do_flush) begin
            head_in  = '0;
            tail_in  = '0;
            count_in = '0;
         end
         if (do_pop) begin
            head_in  = next_slot(head_ff);
            count_in = count_ff - 1'b1;
         end
         if (do_push) begin
            tail_in  = next_slot(tail_ff);
            count_in = count_ff + 1'b1;
         end
         if (rf_we) begin
            rf_valid_in[addr[7:0]] = 1'b1;
         end
      end
   end

   // result stage into the output register
   always_comb begin
      unique case (stage_ff.sel)
         SEL_IMM:   result_byte = stage_ff.imm;
         SEL_COLOR: result_byte = color_rd_ff;
         SEL_RF:    result_byte = stage_ff.rf_valid ? rf_rd_ff : rf_reset_value(stage_ff.rf_idx);
         SEL_QMOD:  result_byte = stage_ff.has_key ? {1'b1, key_rd_ff.mods[6:0]} : 8'h00;
         SEL_QASC:  result_byte = stage_ff.has_key ? key_rd_ff.ascii : 8'h00;
         SEL_QPET:  result_byte = stage_ff.has_key ? key_rd_ff.petscii : 8'h00;
         default:   result_byte = 8'h00;
      endcase

      busy_in        = busy_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_handled_in = rsp_handled_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (stage_move) begin
         busy_in        = 1'b0;
         rsp_valid_in   = 1'b1;
         rsp_data_in    = stage_ff.handled ? result_byte : 8'h00;
         rsp_handled_in = stage_ff.handled;
      end
      if (accept) begin
         busy_in = 1'b1;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_handled_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_2k_ff      <= 1'b0;
         clr_busy_ff    <= 1'b1;
         clr_idx_ff     <= '0;
         rf_valid_ff    <= '0;
         head_ff        <= '0;
         tail_ff        <= '0;
         count_ff       <= '0;
         busy_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            cfg_2k_ff <= csr_wdata[0];
         end
         if (clr_busy_ff) begin
            clr_idx_ff <= clr_idx_ff + 1'b1;
            if (clr_idx_ff == COLOR_AW'(COLOR_DEPTH - 1)) begin
               clr_busy_ff <= 1'b0;
            end
         end
         rf_valid_ff  <= rf_valid_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= stage_in;
      end
      rsp_data_ff    <= rsp_data_in;
      rsp_handled_ff <= rsp_handled_in;
   end

   // colour ram, cleared after reset
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         color_mem[clr_idx_ff] <= 8'h00;
      end else if (accept && color_we) begin
         color_mem[addr[COLOR_AW-1:0]] <= wdata;
      end
      if (accept) begin
         color_rd_ff <= color_mem[addr[COLOR_AW-1:0]];
      end
   end

   // system register file
   always_ff @(posedge clock) begin
      if (accept && rf_we) begin
         rf_mem[addr[7:0]] <= wdata;
      end
      if (accept) begin
         rf_rd_ff <= rf_mem[addr[7:0]];
      end
   end

   // key queue storage, head entry read with the transfer
   always_ff @(posedge clock) begin
      if (accept && do_push) begin
         key_mem[tail_ff] <= push_entry;
      end
      if (accept) begin
         key_rd_ff <= key_mem[head_ff];
      end
   end

endmodule

// ----- test/tb_io_window_with_key_queue.sv -----
// self-checking testbench for the i/o window with key queue, directed and random bus traffic
module tb_io_window_with_key_queue;
   import iowkq_pkg::*;

   localparam int KQ_DEPTH = 16;
   localparam int KQ_PTR_W = $clog2(KQ_DEPTH);
   localparam logic [1:0] OP_NONE = 2'd3;
   localparam logic [15:0] COLOR_2K_LO = COLOR_1K_HI + 16'd1;
   localparam int N_RANDOM_PHASES = 8;
   localparam int ITEMS_PER_PHASE = 140;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] addr;
      logic [7:0]  wdata;
      logic [7:0]  kasc;
      logic [7:0]  kpet;
      logic [7:0]  kmod;
      logic [7:0]  live;
   } bus_item_type;

   typedef struct packed {
      logic [7:0] data;
      logic       handled;
   } io_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [0:0]  csr_wdata = 1'b0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic [1:0]  req_tuser = OP_READ;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic [0:0]  rsp_tuser;

   // mirror of the block state
   logic [7:0]    sys_regs [256];
   logic [7:0]    color_mem [COLOR_DEPTH];
   key_entry_type key_slots [KQ_DEPTH];
   logic [KQ_PTR_W-1:0] key_head, key_tail;
   int            key_count;
   logic          color_2k;

   bus_item_type  pending_req [$];
   io_result_type result_expect [$];
   bit         req_fire = 1'b0;
   int         send_idle_pct = 0;
   int         rx_stall_pct = 0;
   int         err_count = 0;

   io_window_with_key_queue #(.KEY_QUEUE_DEPTH(KQ_DEPTH)) u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   task automatic reset_window_state();
      for (int i = 0; i < 256; i++) sys_regs[8'(i)] = 8'h00;
      for (int i = 0; i < COLOR_DEPTH; i++) color_mem[COLOR_AW'(i)] = 8'h00;
      sys_regs[8'h00] = 8'h80;
      sys_regs[8'h29] = 8'h03;
      sys_regs[8'h31] = 8'h08;
      sys_regs[8'h32] = 8'h4D;
      sys_regs[8'h33] = 8'h4D;
      sys_regs[8'h34] = 8'h53;
      sys_regs[8'h35] = 8'h4D;
      sys_regs[8'h7F] = 8'h55;
      sys_regs[8'hC5] = 8'h01;
      key_head = '0;
      key_tail = '0;
      key_count = 0;
      color_2k = 1'b0;
   endtask

   // applies one access to the mirror and returns the byte and handled flag it should give
   task automatic predict_access(input bus_item_type r, output io_result_type res);
      key_entry_type h;
      logic has_key, flop_hit, col_hit, col_on, sys_hit;
      h = key_slots[key_head];
      has_key = key_count != 0;
      flop_hit = r.addr >= FLOPPY_LO && r.addr <= FLOPPY_HI;
      col_hit = r.addr >= COLOR_LO && r.addr <= COLOR_HI;
      col_on = r.addr <= COLOR_1K_HI || color_2k;
      sys_hit = r.addr >= SYS_LO && r.addr <= SYS_HI
                && !(r.addr >= DECLINE_LO && r.addr <= DECLINE_HI);
      res = '0;
      case (r.op)
         OP_READ: begin
            if (flop_hit) begin
               res.handled = 1'b1;
               res.data = (r.addr[4:0] == FLOPPY_STATUS_OFS) ? FLOPPY_STATUS : 8'h00;
            end else if (col_hit) begin
               res.handled = col_on;
               if (col_on) res.data = color_mem[r.addr[10:0]];
            end else if (sys_hit) begin
               res.handled = 1'b1;
               case (r.addr)
                  KEY_MODS:    res.data = has_key ? {1'b1, h.mods[6:0]} : 8'h00;
                  KEY_ASCII:   res.data = has_key ? h.ascii : 8'h00;
                  KEY_LIVE:    res.data = r.live;
                  KEY_PETSCII: res.data = has_key ? h.petscii : 8'h00;
                  default:     res.data = sys_regs[r.addr[7:0]];
               endcase
            end
         end
         OP_WRITE: begin
            if (col_hit) begin
               res.handled = col_on;
               if (col_on) color_mem[r.addr[10:0]] = r.wdata;
            end else if (sys_hit) begin
               res.handled = 1'b1;
               case (r.addr)
                  KEY_MODS: begin
                     if (!r.wdata[7]) begin
                        key_head = '0;
                        key_tail = '0;
                        key_count = 0;
                     end
                  end
                  KEY_ASCII, KEY_PETSCII: begin
                     if (key_count != 0) begin
                        key_head = (key_head == KQ_PTR_W'(KQ_DEPTH - 1)) ? '0
                                   : key_head + 1'b1;
                        key_count--;
                     end
                  end
                  default: sys_regs[r.addr[7:0]] = r.wdata;
               endcase
            end
         end
         OP_PUSH: begin
            if (key_count < KQ_DEPTH) begin
               key_slots[key_tail] = '{mods: r.kmod, petscii: r.kpet, ascii: r.kasc};
               key_tail = (key_tail == KQ_PTR_W'(KQ_DEPTH - 1)) ? '0 : key_tail + 1'b1;
               key_count++;
               res.handled = 1'b1;
            end
         end
         default: ;
      endcase
   endtask

   function automatic bus_item_type make_item(logic [1:0] op, logic [15:0] a, logic [7:0] wd);
      bus_item_type it;
      it.op = op;
      it.addr = a;
      it.wdata = wd;
      it.kasc = 8'($urandom);
      it.kpet = 8'($urandom);
      it.kmod = 8'($urandom);
      it.live = 8'($urandom);
      return it;
   endfunction

   function automatic logic [15:0] pick_addr();
      logic [15:0] a;
      case ($urandom_range(9))
         0: a = FLOPPY_LO + 16'($urandom_range(31));
         // a few hot colour cells so writes get read back
         1: a = COLOR_LO + 16'($urandom_range(15));
         2: a = COLOR_2K_LO + 16'($urandom_range(15));
         3: a = COLOR_LO + 16'($urandom_range(COLOR_DEPTH - 1));
         4, 5: a = SYS_LO + 16'($urandom_range(255));
         6: begin
            case ($urandom_range(3))
               0: a = KEY_MODS;
               1: a = KEY_ASCII;
               2: a = KEY_LIVE;
               default: a = KEY_PETSCII;
            endcase
         end
         7: begin
            case ($urandom_range(9))
               0: a = FLOPPY_LO - 16'd1;
               1: a = FLOPPY_HI + 16'd1;
               2: a = COLOR_LO - 16'd1;
               3: a = COLOR_HI + 16'd1;
               4: a = SYS_LO - 16'd1;
               5: a = SYS_HI + 16'd1;
               6: a = DECLINE_LO - 16'd1;
               7: a = DECLINE_HI + 16'd1;
               8: a = COLOR_1K_HI;
               default: a = COLOR_HI;
            endcase
         end
         default: a = 16'($urandom);
      endcase
      return a;
   endfunction

   // appends one item to the driver queue
   task automatic add_req(input bus_item_type it);
      pending_req = {pending_req, it};
   endtask

   task automatic queue_random(int n);
      int made, burst, r;
      made = 0;
      while (made < n) begin
         case ($urandom_range(9))
            0: begin
               // push burst, often runs into a full queue
               burst = $urandom_range(1, 20);
               repeat (burst) add_req(make_item(OP_PUSH, 16'($urandom), 8'($urandom)));
               made += burst;
            end
            1: begin
               // look at the head, then pop it
               burst = $urandom_range(1, 6);
               repeat (burst) begin
                  add_req(make_item(OP_READ, KEY_MODS, 8'($urandom)));
                  add_req(make_item(OP_READ, KEY_ASCII, 8'($urandom)));
                  add_req(make_item(OP_READ, KEY_PETSCII, 8'($urandom)));
                  add_req(make_item(OP_WRITE,
                     $urandom_range(1) ? KEY_ASCII : KEY_PETSCII, 8'($urandom)));
               end
               made += 4 * burst;
            end
            default: begin
               r = $urandom_range(99);
               if (r < 40) add_req(make_item(OP_READ, pick_addr(), 8'($urandom)));
               else if (r < 72) add_req(make_item(OP_WRITE, pick_addr(), 8'($urandom)));
               else if (r < 95) add_req(make_item(OP_PUSH, 16'($urandom), 8'($urandom)));
               else add_req(make_item(OP_NONE, pick_addr(), 8'($urandom)));
               made++;
            end
         endcase
      end
   endtask

   task automatic set_color_mode(logic v);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_req.size() != 0 || req_tvalid || result_expect.size() != 0)
         @(posedge clock);
   endtask

   // driver
   always @(negedge clock) begin : drive
      bus_item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (!req_tvalid || req_fire) begin
            if (pending_req.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = pending_req.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {nxt.live, nxt.kmod, nxt.kpet, nxt.kasc, nxt.wdata, nxt.addr};
               req_tuser <= nxt.op;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= $urandom_range(99) >= rx_stall_pct;
      end
   end

   // monitor: predict on every request transfer, check every result transfer
   always @(posedge clock) begin : monitor
      bus_item_type  got;
      io_result_type res, want;
      if (reset) begin
         reset_window_state();
         req_fire = 1'b0;
      end else begin
         if (csr_we) color_2k = csr_wdata[0];
         req_fire = req_tvalid && req_tready;
         if (req_fire) begin
            got.op = req_tuser;
            {got.live, got.kmod, got.kpet, got.kasc, got.wdata, got.addr} = req_tdata;
            predict_access(got, res);
            result_expect = {result_expect, res};
         end
         if (rsp_tvalid && rsp_tready) begin
            if (result_expect.size() == 0) begin
               $error("result transfer with nothing expected: read_data %h handled %b",
                      rsp_tdata, rsp_tuser[0]);
               err_count++;
            end else begin
               want = result_expect.pop_front();
               if (rsp_tdata !== want.data) begin
                  $error("read_data: expected %h, got %h", want.data, rsp_tdata);
                  err_count++;
               end
               if (rsp_tuser[0] !== want.handled) begin
                  $error("handled: expected %b, got %b", want.handled, rsp_tuser[0]);
                  err_count++;
               end
            end
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // colour ram is still clearing here, the write is taken anyway
      set_color_mode(1'b0);
      add_req(make_item(OP_READ, FLOPPY_LO, 8'h00));
      add_req(make_item(OP_READ, FLOPPY_LO + 16'd3, 8'h00));
      add_req(make_item(OP_READ, FLOPPY_HI, 8'h00));
      add_req(make_item(OP_WRITE, FLOPPY_LO + 16'd3, 8'hFF));
      add_req(make_item(OP_WRITE, COLOR_LO, 8'h5A));
      add_req(make_item(OP_READ, COLOR_LO, 8'h00));
      add_req(make_item(OP_WRITE, COLOR_1K_HI, 8'hA5));
      add_req(make_item(OP_READ, COLOR_1K_HI, 8'h00));
      add_req(make_item(OP_WRITE, COLOR_2K_LO, 8'h3C));
      add_req(make_item(OP_READ, COLOR_HI, 8'h00));
      add_req(make_item(OP_READ, SYS_LO, 8'h00));
      add_req(make_item(OP_READ, SYS_LO + 16'hC5, 8'h00));
      add_req(make_item(OP_READ, DECLINE_LO, 8'h00));
      add_req(make_item(OP_WRITE, DECLINE_HI, 8'h12));
      add_req(make_item(OP_READ, DECLINE_HI + 16'd1, 8'h00));
      add_req(make_item(OP_WRITE, SYS_HI, 8'h00));
      add_req(make_item(OP_READ, SYS_HI, 8'h00));
      add_req(make_item(OP_READ, KEY_ASCII, 8'h00));
      add_req(make_item(OP_READ, KEY_MODS, 8'h00));
      add_req(make_item(OP_WRITE, KEY_PETSCII, 8'h00));
      add_req(make_item(OP_WRITE, KEY_LIVE, 8'h77));
      add_req(make_item(OP_READ, KEY_LIVE, 8'h00));
      add_req(make_item(OP_NONE, SYS_LO, 8'hFF));
      add_req(make_item(OP_READ, 16'h0000, 8'h00));
      add_req(make_item(OP_READ, 16'hFFFF, 8'h00));
      // one push past a full queue is dropped
      repeat (KQ_DEPTH + 1) add_req(make_item(OP_PUSH, 16'($urandom), 8'($urandom)));
      add_req(make_item(OP_READ, KEY_MODS, 8'h00));
      add_req(make_item(OP_READ, KEY_PETSCII, 8'h00));
      add_req(make_item(OP_WRITE, KEY_ASCII, 8'h00));
      add_req(make_item(OP_WRITE, KEY_MODS, 8'h80));
      add_req(make_item(OP_READ, KEY_ASCII, 8'h00));
      add_req(make_item(OP_WRITE, KEY_MODS, 8'h7F));
      add_req(make_item(OP_READ, KEY_ASCII, 8'h00));
      wait_drained();

      set_color_mode(1'b1);
      add_req(make_item(OP_WRITE, COLOR_2K_LO, 8'hC3));
      add_req(make_item(OP_READ, COLOR_2K_LO, 8'h00));
      add_req(make_item(OP_WRITE, COLOR_HI, 8'hFF));
      add_req(make_item(OP_READ, COLOR_HI, 8'h00));
      add_req(make_item(OP_READ, COLOR_LO, 8'h00));
      wait_drained();

      for (int ph = 0; ph < N_RANDOM_PHASES; ph++) begin
         case (ph / 2)
            0: begin send_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin send_idle_pct = 58; rx_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rx_stall_pct = 58; end
            default: begin send_idle_pct = 20; rx_stall_pct = 20; end
         endcase
         set_color_mode(ph[0]);
         queue_random(ITEMS_PER_PHASE);
         wait_drained();
      end

      repeat (10) @(posedge clock);
      if (err_count == 0) begin
         $display("tb_io_window_with_key_queue: PASS");
      end else begin
         $display("tb_io_window_with_key_queue: FAIL");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("tb_io_window_with_key_queue: FAIL");
      $finish;
   end

endmodule

// ----- io_window_with_key_queue.f -----
src/iowkq_pkg.sv
src/io_window_with_key_queue.sv
test/tb_io_window_with_key_queue.sv
